// ===== hdl/ebm_pkg.sv =====
// Shared types and constants for the extent block map.
`timescale 1ns / 1ps

package ebm_pkg;

    // Function codes carried on the input channel.
    localparam logic [1:0] FUNC_HDR   = 2'd0;
    localparam logic [1:0] FUNC_EXT   = 2'd1;
    localparam logic [1:0] FUNC_XLATE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_MAPPED    = 2'd0;
    localparam logic [1:0] STATUS_NO_EXTENT = 2'd1;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd2;
    localparam logic [1:0] STATUS_DEPTH     = 2'd3;

    localparam logic [15:0] EXT_MAGIC   = 16'hF30A;
    localparam logic [15:0] UNINIT_BIAS = 16'd32768;

    // Clipped entry count field, wide enough for the largest table size.
    localparam int CNT_FIELD_W = 5;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // One classified command. For a translate, first holds the logical block.
    typedef struct packed {
        logic [1:0]             kind;
        logic                   magic_ok;
        logic                   depth_zero;
        logic [CNT_FIELD_W-1:0] count;
        logic [1:0]             slot;
        logic [31:0]            first;
        logic [15:0]            len;
        logic [47:0]            phys;
    } cmd_t;

endpackage

// ===== hdl/ebm_front.sv =====
// Front end: decodes input words into queue commands and drops no-op words.
`timescale 1ns / 1ps

module ebm_front #(
    parameter int MaxExtents = 4
) (
    input  logic               push,
    input  logic               full,
    input  logic [1:0]         func,
    input  logic [15:0]        hdr_magic,
    input  logic [15:0]        hdr_entries,
    input  logic [15:0]        hdr_depth,
    input  logic [1:0]         slot,
    input  logic [31:0]        ext_logical,
    input  logic [15:0]        ext_len_raw,
    input  logic [15:0]        ext_phys_hi,
    input  logic [31:0]        ext_phys_lo,
    input  logic [31:0]        logical_block,
    output logic               cmd_push,
    output ebm_pkg::cmd_t      cmd
);

    import ebm_pkg::*;

    logic accept;
    logic keep;

    assign accept = push && !full;

    always_comb
    begin
        case (func)
            FUNC_HDR:   keep = 1'b1;
            FUNC_EXT:   keep = (int'(slot) < MaxExtents);
            FUNC_XLATE: keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    assign cmd_push = accept && keep;

    always_comb
    begin
        cmd.kind       = func;
        cmd.magic_ok   = (hdr_magic == EXT_MAGIC);
        cmd.depth_zero = (hdr_depth == 16'd0);
        if (int'(hdr_entries) < MaxExtents)
        begin
            cmd.count = hdr_entries[CNT_FIELD_W-1:0];
        end
        else
        begin
            cmd.count = CNT_FIELD_W'(MaxExtents);
        end
        cmd.slot = slot;
        cmd.first = (func == FUNC_XLATE) ? logical_block : ext_logical;
        // A raw length above the bias marks an uninitialized extent.
        cmd.len  = (ext_len_raw > UNINIT_BIAS) ? (ext_len_raw - UNINIT_BIAS) : ext_len_raw;
        cmd.phys = {ext_phys_hi, ext_phys_lo};
    end

endmodule

// ===== hdl/ebm_fifo.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module ebm_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  ebm_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output ebm_pkg::cmd_t rd_data,
    output logic          full,
    output logic          empty
);

    import ebm_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_wr;
    logic              do_rd;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/ebm_back.sv =====
// Back end: applies table loads and walks the extent slots for translations.
`timescale 1ns / 1ps

module ebm_back #(
    parameter int MaxExtents = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ebm_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    input  logic          pop,
    output logic          empty,
    output logic [48:0]   physical_block,
    output logic          mapped,
    output logic [1:0]    status
);

    import ebm_pkg::*;

    localparam int CNT_W = $clog2(MaxExtents + 1);
    localparam int IDX_W = (MaxExtents > 1) ? $clog2(MaxExtents) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [31:0] first_mem [MaxExtents];
    logic [15:0] len_mem   [MaxExtents];
    logic [47:0] phys_mem  [MaxExtents];

    logic [1:0]       state_reg, state_next;
    logic             magic_ok_reg, magic_ok_next;
    logic             depth_zero_reg, depth_zero_next;
    logic [CNT_W-1:0] used_count_reg, used_count_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [31:0]      lb_reg, lb_next;
    logic [31:0]      off_reg, off_next;
    logic [48:0]      res_phys_reg, res_phys_next;
    logic             res_mapped_reg, res_mapped_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic             out_valid_reg, out_valid_next;
    logic [48:0]      out_phys_reg, out_phys_next;
    logic             out_mapped_reg, out_mapped_next;
    logic [1:0]       out_status_reg, out_status_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [32:0]      diff;
    logic             hit;
    logic             out_taken;
    logic             out_free;

    assign rd_idx = scan_idx_reg[IDX_W-1:0];
    assign wr_idx = IDX_W'(cmd.slot);

    // The subtraction is one bit wider so a block below the extent start shows as a borrow.
    assign diff = {1'b0, lb_reg} - {1'b0, first_mem[rd_idx]};
    assign hit  = !diff[32] && (diff[31:0] < {16'd0, len_mem[rd_idx]});

    assign out_taken = pop && out_valid_reg;
    assign out_free  = !out_valid_reg || out_taken;

    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid;
    assign wr_en   = cmd_pop && (cmd.kind == FUNC_EXT);

    always_comb
    begin
        state_next      = state_reg;
        magic_ok_next   = magic_ok_reg;
        depth_zero_next = depth_zero_reg;
        used_count_next = used_count_reg;
        scan_idx_next   = scan_idx_reg;
        lb_next         = lb_reg;
        off_next        = off_reg;
        res_phys_next   = res_phys_reg;
        res_mapped_next = res_mapped_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_taken ? 1'b0 : out_valid_reg;
        out_phys_next   = out_phys_reg;
        out_mapped_next = out_mapped_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        FUNC_HDR:
                        begin
                            magic_ok_next   = cmd.magic_ok;
                            depth_zero_next = cmd.depth_zero;
                            used_count_next = cmd.count[CNT_W-1:0];
                        end
                        FUNC_XLATE:
                        begin
                            lb_next         = cmd.first;
                            scan_idx_next   = '0;
                            res_phys_next   = '0;
                            res_mapped_next = 1'b0;
                            if (!magic_ok_reg)
                            begin
                                res_status_next = STATUS_BAD_MAGIC;
                                state_next      = S_OUT;
                            end
                            else if (!depth_zero_reg)
                            begin
                                res_status_next = STATUS_DEPTH;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_idx_reg >= used_count_reg)
                begin
                    res_status_next = STATUS_NO_EXTENT;
                    state_next      = S_OUT;
                end
                else if (hit)
                begin
                    off_next        = diff[31:0];
                    res_mapped_next = 1'b1;
                    res_status_next = STATUS_MAPPED;
                    state_next      = S_ADD;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_ADD:
            begin
                res_phys_next = {1'b0, phys_mem[rd_idx]} + {17'd0, off_reg};
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_phys_next   = res_phys_reg;
                    out_mapped_next = res_mapped_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            magic_ok_reg   <= 1'b0;
            depth_zero_reg <= 1'b0;
            used_count_reg <= '0;
            scan_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            magic_ok_reg   <= magic_ok_next;
            depth_zero_reg <= depth_zero_next;
            used_count_reg <= used_count_next;
            scan_idx_reg   <= scan_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lb_reg         <= lb_next;
        off_reg        <= off_next;
        res_phys_reg   <= res_phys_next;
        res_mapped_reg <= res_mapped_next;
        res_status_reg <= res_status_next;
        out_phys_reg   <= out_phys_next;
        out_mapped_reg <= out_mapped_next;
        out_status_reg <= out_status_next;
        if (wr_en)
        begin
            first_mem[wr_idx] <= cmd.first;
            len_mem[wr_idx]   <= cmd.len;
            phys_mem[wr_idx]  <= cmd.phys;
        end
    end

    assign empty          = !out_valid_reg;
    assign physical_block = out_phys_reg;
    assign mapped         = out_mapped_reg;
    assign status         = out_status_reg;

endmodule

// ===== hdl/extent_block_map.sv =====
// Top level of the extent block map: front end, command queue and back end.
`timescale 1ns / 1ps
//
// Translates a logical file block to a physical block through a table of
// up to MAX_EXTENTS inline extents. Words are pushed with push while full is
// low; func selects a header load, an extent slot load or a translation.
// Loads give no result. Each translation gives one result word, read from
// physical_block, mapped and status while empty is low and taken with pop.
// Accepted words other than no-ops enter a four-entry command queue; an idle
// back end takes one command per cycle from it and is busy with a translation
// until its result is registered. The slot walk checks one extent per cycle;
// a hit then passes through the add and output states, a miss goes from the
// walk to the output state, and a bad header goes from idle straight to the
// output state. A load is applied as the back end takes it, and it stays idle.
// While a result waits on a stalled receiver, one more translation can finish
// into the back end's holding register and the queue keeps accepting words
// until it fills. Reset empties the queue and the result port and clears the
// header state; slot contents are left as they were and must be loaded
// before they are used.
//

module extent_block_map #(
    parameter int MAX_EXTENTS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  func,
    input  logic [15:0] hdr_magic,
    input  logic [15:0] hdr_entries,
    input  logic [15:0] hdr_depth,
    input  logic [1:0]  slot,
    input  logic [31:0] ext_logical,
    input  logic [15:0] ext_len_raw,
    input  logic [15:0] ext_phys_hi,
    input  logic [31:0] ext_phys_lo,
    input  logic [31:0] logical_block,
    output logic        empty,
    input  logic        pop,
    output logic [48:0] physical_block,
    output logic        mapped,
    output logic [1:0]  status
);

    import ebm_pkg::*;

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic front_push;
    logic q_empty;
    logic back_pop;

    ebm_front #(
        .MaxExtents (MAX_EXTENTS)
    ) u_front (
        .push          (push),
        .full          (full),
        .func          (func),
        .hdr_magic     (hdr_magic),
        .hdr_entries   (hdr_entries),
        .hdr_depth     (hdr_depth),
        .slot          (slot),
        .ext_logical   (ext_logical),
        .ext_len_raw   (ext_len_raw),
        .ext_phys_hi   (ext_phys_hi),
        .ext_phys_lo   (ext_phys_lo),
        .logical_block (logical_block),
        .cmd_push      (front_push),
        .cmd           (front_cmd)
    );

    ebm_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_cmd),
        .rd_en   (back_pop),
        .rd_data (back_cmd),
        .full    (full),
        .empty   (q_empty)
    );

    ebm_back #(
        .MaxExtents (MAX_EXTENTS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (back_cmd),
        .cmd_valid      (!q_empty),
        .cmd_pop        (back_pop),
        .pop            (pop),
        .empty          (empty),
        .physical_block (physical_block),
        .mapped         (mapped),
        .status         (status)
    );

endmodule

// ===== hdl/ebm_checker.sv =====
// Port-level checks on the result channel of the extent block map.
`timescale 1ns / 1ps

module ebm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [48:0] physical_block,
    input logic        mapped,
    input logic [1:0]  status
);

    import ebm_pkg::*;

    // A waiting result stays until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(physical_block) && $stable(status)))
    else $error("result word changed or vanished while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && mapped) |-> (status == STATUS_MAPPED))
    else $error("mapped result without mapped status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == STATUS_MAPPED)) |-> mapped)
    else $error("mapped status without mapped flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !mapped) |-> (physical_block == 49'd0))
    else $error("unmapped result with nonzero physical block");

endmodule

bind extent_block_map ebm_checker u_ebm_checker (.*);
